// ===== rtl/rau_pkg.sv =====
package rau_pkg;

	localparam int WORD_BITS = 32;
	localparam int CNT_W = $clog2(WORD_BITS + 1);

	localparam logic [2:0] ACT_ADD = 3'd0;
	localparam logic [2:0] ACT_SUB = 3'd1;
	localparam logic [2:0] ACT_MUL = 3'd2;
	localparam logic [2:0] ACT_DIV = 3'd3;
	localparam logic [2:0] ACT_NEG = 3'd4;
	localparam logic [2:0] ACT_REC = 3'd5;
	localparam logic [2:0] ACT_CMP = 3'd6;
	localparam logic [2:0] ACT_NOP = 3'd7; // unused action, plain 0/1 result

	localparam logic [1:0] ERR_OK   = 2'd0;
	localparam logic [1:0] ERR_DIV0 = 2'd1;
	localparam logic [1:0] ERR_UNDEF = 2'd2;

	// datapath commands
	localparam logic [3:0] CMD_NOP      = 4'd0;
	localparam logic [3:0] CMD_LOAD     = 4'd1;
	localparam logic [3:0] CMD_RED_A    = 4'd2;  // start reduction of operand a
	localparam logic [3:0] CMD_RED_B    = 4'd3;
	localparam logic [3:0] CMD_RED_R    = 4'd4;  // start reduction of result
	localparam logic [3:0] CMD_GCD_STEP = 4'd5;  // begin remainder x % y
	localparam logic [3:0] CMD_DIV_BIT  = 4'd6;  // one restoring division bit
	localparam logic [3:0] CMD_REM_DONE = 4'd7;  // rotate x,y <= y,r
	localparam logic [3:0] CMD_QUO_N    = 4'd8;  // start num / g
	localparam logic [3:0] CMD_QUO_D    = 4'd9;  // start den / g
	localparam logic [3:0] CMD_QUO_DONE = 4'd10; // store quotient
	localparam logic [3:0] CMD_MUL1     = 4'd11; // products stage 1
	localparam logic [3:0] CMD_MUL2     = 4'd12; // combine into result
	localparam logic [3:0] CMD_FINISH   = 4'd13;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] tgt; // 0 a, 1 b, 2 result
	} cmd_t;

	typedef struct packed {
		logic       y_zero;
		logic       g_zero;
		logic       div_done;
		logic       a_num_zero;
		logic       b_num_zero;
		logic [2:0] action;
	} stat_t;

endpackage

// ===== rtl/rau_datapath.sv =====
module rau_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rau_pkg::cmd_t                        cmd,
	output rau_pkg::stat_t                       stat,
	input  logic [2:0]                           action,
	input  logic signed [31:0]                   a_num,
	input  logic signed [31:0]                   a_den,
	input  logic signed [31:0]                   b_num,
	input  logic signed [31:0]                   b_den,
	input  logic [1:0]                           err_in,
	output logic signed [31:0]                   res_num,
	output logic signed [31:0]                   res_den,
	output logic                                 is_equal,
	output logic                                 is_less,
	output logic                                 is_greater
);
	localparam int W = rau_pkg::WORD_BITS;

	logic [2:0]          act_q;
	logic [W-1:0]        an_q, ad_q, bn_q, bd_q, rn_q, rd_q;
	logic [W-1:0]        x_q, y_q;
	logic [W-1:0]        g_q;
	// shared restoring divider: dividend magnitude, divisor magnitude
	logic [W-1:0]        dvd_q, dvs_q, rem_q, quo_q;
	logic                neg_q;
	logic [rau_pkg::CNT_W-1:0] cnt_q;
	logic [W-1:0]        p1_q, p2_q, p3_q, p4_q;
	logic [W-1:0]        w_n, w_d;
	logic [W:0]          trial;
	logic [W-1:0]        rem_sh, quo_signed, rem_signed;

	function automatic logic [W-1:0] fin(input logic signed [31:0] v);
		logic signed [63:0] e;
		e = 64'(v);
		return e[W-1:0];
	endfunction

	function automatic logic [W-1:0] magn(input logic [W-1:0] v);
		return v[W-1] ? W'(-v) : v;
	endfunction

	function automatic logic [31:0] fout(input logic [W-1:0] v);
		logic signed [W-1:0] s;
		logic signed [63:0]  e;
		s = v;
		e = 64'(s);
		return e[31:0];
	endfunction

	// pick the fraction being worked on
	always_comb begin
		case (cmd.tgt)
			2'd0:    begin w_n = an_q; w_d = ad_q; end
			2'd1:    begin w_n = bn_q; w_d = bd_q; end
			default: begin w_n = rn_q; w_d = rd_q; end
		endcase
	end

	assign rem_sh     = {rem_q[W-2:0], dvd_q[W-1]};
	assign trial      = {1'b0, rem_sh} - {1'b0, dvs_q};
	assign quo_signed = neg_q ? W'(-quo_q) : quo_q;
	assign rem_signed = neg_q ? W'(-rem_q) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cmd.op)
				rau_pkg::CMD_GCD_STEP, rau_pkg::CMD_QUO_N,
				rau_pkg::CMD_QUO_D:   cnt_q <= rau_pkg::CNT_W'(W);
				rau_pkg::CMD_DIV_BIT: cnt_q <= cnt_q - 1'b1;
				default:              cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			rau_pkg::CMD_LOAD: begin
				act_q <= action;
				an_q <= fin(a_num); ad_q <= fin(a_den);
				bn_q <= fin(b_num); bd_q <= fin(b_den);
			end
			rau_pkg::CMD_RED_A, rau_pkg::CMD_RED_B, rau_pkg::CMD_RED_R: begin
				x_q <= w_n; y_q <= w_d;
			end
			rau_pkg::CMD_GCD_STEP: begin
				dvd_q <= magn(x_q); dvs_q <= magn(y_q);
				rem_q <= '0; quo_q <= '0; neg_q <= x_q[W-1];
			end
			rau_pkg::CMD_DIV_BIT: begin
				dvd_q <= {dvd_q[W-2:0], 1'b0};
				if (!trial[W]) begin
					rem_q <= trial[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
			end
			rau_pkg::CMD_REM_DONE: begin
				x_q <= y_q; y_q <= rem_signed; g_q <= y_q;
			end
			rau_pkg::CMD_QUO_N, rau_pkg::CMD_QUO_D: begin
				dvd_q <= magn(cmd.op == rau_pkg::CMD_QUO_N ? w_n : w_d);
				dvs_q <= magn(x_q);
				rem_q <= '0; quo_q <= '0;
				neg_q <= (cmd.op == rau_pkg::CMD_QUO_N ? w_n[W-1] : w_d[W-1]) ^ x_q[W-1];
			end
			rau_pkg::CMD_MUL1: begin
				case (act_q)
					rau_pkg::ACT_MUL: begin
						p1_q <= W'(an_q * bn_q); p2_q <= '0;
						p3_q <= W'(ad_q * bd_q); p4_q <= '0;
					end
					rau_pkg::ACT_DIV: begin
						p1_q <= W'(an_q * bd_q); p2_q <= '0;
						p3_q <= W'(ad_q * bn_q); p4_q <= '0;
					end
					default: begin
						p1_q <= W'(an_q * bd_q); p2_q <= W'(bn_q * ad_q);
						p3_q <= W'(ad_q * bd_q); p4_q <= '0;
					end
				endcase
			end
			rau_pkg::CMD_MUL2: begin
				case (act_q)
					rau_pkg::ACT_ADD: begin rn_q <= p1_q + p2_q; rd_q <= p3_q; end
					rau_pkg::ACT_SUB: begin rn_q <= p1_q - p2_q; rd_q <= p3_q; end
					rau_pkg::ACT_NEG: begin rn_q <= W'(-an_q); rd_q <= ad_q; end
					rau_pkg::ACT_REC: begin rn_q <= ad_q; rd_q <= an_q; end
					default:          begin rn_q <= p1_q + p4_q; rd_q <= p3_q; end
				endcase
			end
			default: ;
		endcase
		// quotient write-back into the chosen fraction
		if (cmd.op == rau_pkg::CMD_QUO_DONE) begin
			case (cmd.tgt)
				2'd0:    if (g_q[0]) an_q <= quo_signed; else ad_q <= quo_signed;
				2'd1:    if (g_q[0]) bn_q <= quo_signed; else bd_q <= quo_signed;
				default: if (g_q[0]) rn_q <= quo_signed; else rd_q <= quo_signed;
			endcase
		end
		// g_q[0] marks numerator pass during quotients
		if (cmd.op == rau_pkg::CMD_QUO_N) g_q <= W'(1);
		if (cmd.op == rau_pkg::CMD_QUO_D) g_q <= '0;
	end

	assign stat.y_zero        = (y_q == '0);
	assign stat.g_zero        = (x_q == '0);
	assign stat.div_done      = (cnt_q == '0);
	assign stat.a_num_zero    = (an_q == '0);
	assign stat.b_num_zero    = (bn_q == '0);
	assign stat.action        = act_q;

	// output register: loaded at finish
	logic signed [31:0] on_q, od_q;
	logic               eq_q, lt_q, gt_q;
	logic               cmp_ok;
	assign cmp_ok = (act_q == rau_pkg::ACT_CMP) && (err_in == rau_pkg::ERR_OK);

	always_ff @(posedge clk) begin
		if (cmd.op == rau_pkg::CMD_FINISH) begin
			if (err_in == rau_pkg::ERR_OK && act_q != rau_pkg::ACT_CMP &&
			    act_q != rau_pkg::ACT_NOP) begin
				on_q <= fout(rn_q); od_q <= fout(rd_q);
			end else begin
				on_q <= 32'sd0; od_q <= 32'sd1;
			end
			eq_q <= cmp_ok && (p1_q == p2_q);
			lt_q <= cmp_ok && ($signed(p1_q) < $signed(p2_q));
			gt_q <= cmp_ok && ($signed(p2_q) < $signed(p1_q));
		end
	end

	assign res_num    = on_q;
	assign res_den    = od_q;
	assign is_equal   = eq_q;
	assign is_less    = lt_q;
	assign is_greater = gt_q;
endmodule

// ===== rtl/rau_ctrl.sv =====
module rau_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	output logic            busy,
	output logic            out_load,
	output rau_pkg::cmd_t   cmd,
	input  rau_pkg::stat_t  stat,
	output logic [1:0]      err
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RED  = 4'd1;
	localparam logic [3:0] S_GCD  = 4'd2;
	localparam logic [3:0] S_DIV  = 4'd3;
	localparam logic [3:0] S_REM  = 4'd4;
	localparam logic [3:0] S_QN   = 4'd5;
	localparam logic [3:0] S_QND  = 4'd6;
	localparam logic [3:0] S_QD   = 4'd7;
	localparam logic [3:0] S_QDD  = 4'd8;
	localparam logic [3:0] S_NEXT = 4'd9;
	localparam logic [3:0] S_MUL1 = 4'd10;
	localparam logic [3:0] S_MUL2 = 4'd11;
	localparam logic [3:0] S_FIN  = 4'd12;
	localparam logic [3:0] S_QWN  = 4'd13;
	localparam logic [3:0] S_QWD  = 4'd14;

	logic [3:0] st_q, st_d;
	logic [1:0] tgt_q, tgt_d;
	logic [1:0] err_q, err_d;
	logic [1:0] qdiv_q, qdiv_d; // 0 = gcd pass, 1 = numerator quotient pass, 2 = denominator quotient pass
	logic       a_bad_q, a_bad_d;
	logic       need_b;

	assign need_b = (stat.action <= rau_pkg::ACT_DIV) || (stat.action == rau_pkg::ACT_CMP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; tgt_q <= '0; err_q <= rau_pkg::ERR_OK;
			qdiv_q <= '0; a_bad_q <= 1'b0;
		end else begin
			st_q <= st_d; tgt_q <= tgt_d; err_q <= err_d;
			qdiv_q <= qdiv_d; a_bad_q <= a_bad_d;
		end
	end

	always_comb begin
		st_d = st_q; tgt_d = tgt_q; err_d = err_q; qdiv_d = qdiv_q; a_bad_d = a_bad_q;
		cmd.op = rau_pkg::CMD_NOP; cmd.tgt = tgt_q;
		out_load = 1'b0;
		case (st_q)
			S_IDLE: if (in_fire) begin
				cmd.op = rau_pkg::CMD_LOAD;
				tgt_d = 2'd0; err_d = rau_pkg::ERR_OK; a_bad_d = 1'b0;
				st_d = S_RED;
			end
			S_RED: begin
				cmd.op = (tgt_q == 2'd0) ? rau_pkg::CMD_RED_A :
				         (tgt_q == 2'd1) ? rau_pkg::CMD_RED_B : rau_pkg::CMD_RED_R;
				st_d = S_GCD;
			end
			// Euclid: loop while y != 0
			S_GCD: begin
				if (stat.y_zero) begin
					if (stat.g_zero) begin
						// 0/0 value
						if (tgt_q == 2'd0) a_bad_d = 1'b1;
						else if (tgt_q == 2'd1) begin
							if (need_b) err_d = rau_pkg::ERR_UNDEF;
						end else err_d = rau_pkg::ERR_UNDEF;
						st_d = S_NEXT;
					end else st_d = S_QN;
				end else begin
					cmd.op = rau_pkg::CMD_GCD_STEP;
					qdiv_d = 2'd0;
					st_d = S_DIV;
				end
			end
			S_DIV: begin
				if (stat.div_done) st_d = (qdiv_q == 2'd0) ? S_REM :
				                          (qdiv_q == 2'd1) ? S_QWN : S_QWD;
				else cmd.op = rau_pkg::CMD_DIV_BIT;
			end
			S_REM: begin
				cmd.op = rau_pkg::CMD_REM_DONE;
				st_d = S_GCD;
			end
			S_QN: begin
				cmd.op = rau_pkg::CMD_QUO_N; qdiv_d = 2'd1; st_d = S_DIV;
			end
			S_QWN: begin
				cmd.op = rau_pkg::CMD_QUO_DONE; st_d = S_QD;
			end
			S_QD: begin
				cmd.op = rau_pkg::CMD_QUO_D; qdiv_d = 2'd2; st_d = S_DIV;
			end
			S_QWD: begin
				cmd.op = rau_pkg::CMD_QUO_DONE; st_d = S_NEXT;
			end
			S_NEXT: begin
				if (tgt_q == 2'd0) begin
					tgt_d = 2'd1; st_d = S_RED;
				end else if (tgt_q == 2'd1) begin
					if (stat.action == rau_pkg::ACT_NOP) st_d = S_FIN;
					else if (a_bad_q || err_q != rau_pkg::ERR_OK) begin
						err_d = rau_pkg::ERR_UNDEF; st_d = S_FIN;
					end else if ((stat.action == rau_pkg::ACT_DIV && stat.b_num_zero) ||
					         (stat.action == rau_pkg::ACT_REC && stat.a_num_zero)) begin
						err_d = rau_pkg::ERR_DIV0; st_d = S_FIN;
					end else st_d = S_MUL1;
				end else st_d = S_FIN;
			end
			S_MUL1: begin
				cmd.op = rau_pkg::CMD_MUL1;
				st_d = (stat.action == rau_pkg::ACT_CMP) ? S_FIN : S_MUL2;
			end
			S_MUL2: begin
				cmd.op = rau_pkg::CMD_MUL2;
				tgt_d = 2'd2; st_d = S_RED;
			end
			S_FIN: begin
				cmd.op = rau_pkg::CMD_FINISH;
				out_load = 1'b1;
				st_d = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end

	assign busy = (st_q != S_IDLE);
	assign err  = err_q;
endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// The operands are taken, then a, b and the result are each reduced on one shared
// bit-serial divider by Euclid remainder steps and two quotient divisions (none for a
// 0/0 value); the products are formed before the result is reduced and finished. The
// time taken depends on the operands; compare, no-op and error cases skip later steps.
// Throughput: one item at a time; the next is taken once the result has been
// transferred out. Reset (arst_n low) clears the controller and output valid.
module rational_arithmetic_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         action,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic signed [31:0] b_den,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] res_num,
	output logic signed [31:0] res_den,
	output logic [1:0]         error_code,
	output logic               is_equal,
	output logic               is_less,
	output logic               is_greater
);
	rau_pkg::cmd_t  cmd;
	rau_pkg::stat_t stat;
	logic           busy, out_load, in_fire;
	logic [1:0]     err, err_q;
	logic           ov_q;

	// hold off new work while a finished result waits
	assign in_ready = !busy && !ov_q;
	assign in_fire  = in_valid && in_ready;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .busy(busy),
		.out_load(out_load), .cmd(cmd), .stat(stat), .err(err)
	);

	rau_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .action(action),
		.a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den), .err_in(err),
		.res_num(res_num), .res_den(res_den), .is_equal(is_equal),
		.is_less(is_less), .is_greater(is_greater)
	);

	// output valid and error code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0; err_q <= rau_pkg::ERR_OK;
		end else begin
			if (out_load) begin
				ov_q <= 1'b1; err_q <= err;
			end else if (out_ready) ov_q <= 1'b0;
		end
	end

	assign out_valid  = ov_q;
	assign error_code = err_q;
endmodule
